// ----- sv/ksr_pkg.sv -----
// Package with the command, status and payload types of the keyed stack.
`default_nettype none
package ksr_pkg;

  localparam int unsigned KeyW    = 16;
  localparam int unsigned ValW    = 32;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CountW  = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [KeyW-1:0]   out_key;
    logic [ValW-1:0]   out_value;
    logic [CountW-1:0] entry_count;
    logic              is_empty;
  } rsp_t;

  // Shift and search controls broadcast to every cell of the row.
  typedef struct packed {
    logic            push;
    logic            pop;
    logic            remove;
    logic [KeyW-1:0] key;
  } ctrl_t;

endpackage
`default_nettype wire

// ----- sv/ksr_cell.sv -----
// One storage cell of the stack row: entry registers, key compare and search hand-off.
`default_nettype none
module ksr_cell #(
  parameter int unsigned VW = 32
) (
  input  logic                     clk_i,
  input  ksr_pkg::ctrl_t           ctrl_i,
  input  logic                     occ_i,
  input  logic [ksr_pkg::KeyW-1:0] prev_key_i,
  input  logic [VW-1:0]            prev_val_i,
  input  logic [ksr_pkg::KeyW-1:0] next_key_i,
  input  logic [VW-1:0]            next_val_i,
  input  logic                     found_i,
  input  logic [ksr_pkg::KeyW-1:0] fkey_i,
  input  logic [VW-1:0]            fval_i,
  output logic [ksr_pkg::KeyW-1:0] key_o,
  output logic [VW-1:0]            val_o,
  output logic                     found_o,
  output logic [ksr_pkg::KeyW-1:0] fkey_o,
  output logic [VW-1:0]            fval_o
);

  logic [ksr_pkg::KeyW-1:0] key_q, key_d;
  logic [VW-1:0]            val_q, val_d;
  logic                     hit;
  logic                     shift_up;

  // The first occupied match seen from the newest end wins.
  assign hit      = occ_i & ~found_i & (key_q == ctrl_i.key);
  assign found_o  = found_i | hit;
  assign fkey_o   = found_i ? fkey_i : key_q;
  assign fval_o   = found_i ? fval_i : val_q;
  assign shift_up = ctrl_i.pop | (ctrl_i.remove & found_o);

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    if (ctrl_i.push) begin
      key_d = prev_key_i;
      val_d = prev_val_i;
    end else if (shift_up) begin
      key_d = next_key_i;
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  assign key_o = key_q;
  assign val_o = val_q;

endmodule
`default_nettype wire

// ----- sv/keyed_stack_with_removal_top.sv -----
// Top level of the keyed stack: command register, cell row, count and result register.
`default_nettype none
// A command is taken when start is high and busy is low. It is registered, executed
// against the row of cells in the next cycle, and its result appears on rsp_o with done_o
// high for exactly one cycle after that; a new command can be started while the previous
// result is shown. The receiver cannot hold a result off: it has to take rsp_o in the one
// cycle that done_o is high. Cell 0 holds the newest entry; push and pop shift the whole
// row by one place, and remove shifts only the cells at and past the matching entry. Find
// and remove pass a found flag with the matching entry down the row, so the execute cycle
// carries a compare plus a ripple through DEPTH cells.
module keyed_stack_with_removal_top #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ksr_pkg::req_t req_i,
  output logic          done_o,
  output ksr_pkg::rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = VALUE_WIDTH;

  ksr_pkg::req_t  req_q;
  logic           pend_q;
  logic [CW-1:0]  cnt_q, cnt_d;
  ksr_pkg::rsp_t  rsp_q, rsp_d;
  logic           done_q;
  ksr_pkg::ctrl_t ctrl;
  logic           full, empty;

  logic [ksr_pkg::KeyW-1:0] key_w  [DEPTH];
  logic [VW-1:0]            val_w  [DEPTH];
  logic                     fnd_w  [DEPTH];
  logic [ksr_pkg::KeyW-1:0] fkey_w [DEPTH];
  logic [VW-1:0]            fval_w [DEPTH];
  logic [VW-1:0]            new_val;

  assign busy    = pend_q;
  assign full    = (cnt_q == CW'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign new_val = VW'(req_q.value);

  always_comb begin
    ctrl.key    = req_q.key;
    ctrl.push   = pend_q & (req_q.command == ksr_pkg::CMD_PUSH) & ~full;
    ctrl.pop    = pend_q & (req_q.command == ksr_pkg::CMD_POP) & ~empty;
    ctrl.remove = pend_q & (req_q.command == ksr_pkg::CMD_REMOVE);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ksr_pkg::KeyW-1:0] pk, nk, fk;
    logic [VW-1:0]            pv, nv, fv;
    logic                     fi;
    if (i == 0) begin : g_head
      assign pk = req_q.key;
      assign pv = new_val;
      assign fi = 1'b0;
      assign fk = '0;
      assign fv = '0;
    end else begin : g_body
      assign pk = key_w[i-1];
      assign pv = val_w[i-1];
      assign fi = fnd_w[i-1];
      assign fk = fkey_w[i-1];
      assign fv = fval_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign nk = key_w[i];
      assign nv = val_w[i];
    end else begin : g_inner
      assign nk = key_w[i+1];
      assign nv = val_w[i+1];
    end

    ksr_cell #(
      .VW(VW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (CW'(i) < cnt_q),
      .prev_key_i (pk),
      .prev_val_i (pv),
      .next_key_i (nk),
      .next_val_i (nv),
      .found_i    (fi),
      .fkey_i     (fk),
      .fval_i     (fv),
      .key_o      (key_w[i]),
      .val_o      (val_w[i]),
      .found_o    (fnd_w[i]),
      .fkey_o     (fkey_w[i]),
      .fval_o     (fval_w[i])
    );
  end

  always_comb begin
    cnt_d             = cnt_q;
    rsp_d.status      = ksr_pkg::ST_OK;
    rsp_d.out_key     = '0;
    rsp_d.out_value   = '0;
    case (req_q.command)
      ksr_pkg::CMD_PUSH: begin
        if (full) begin
          rsp_d.status = ksr_pkg::ST_FULL;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ksr_pkg::CMD_POP, ksr_pkg::CMD_PEEK: begin
        if (empty) begin
          rsp_d.status = ksr_pkg::ST_MISS;
        end else begin
          rsp_d.out_key   = key_w[0];
          rsp_d.out_value = ksr_pkg::ValW'(val_w[0]);
          if (req_q.command == ksr_pkg::CMD_POP) begin
            cnt_d = cnt_q - CW'(1);
          end
        end
      end
      ksr_pkg::CMD_FIND, ksr_pkg::CMD_REMOVE: begin
        if (!fnd_w[DEPTH-1]) begin
          rsp_d.status = ksr_pkg::ST_MISS;
        end else begin
          rsp_d.out_key   = fkey_w[DEPTH-1];
          rsp_d.out_value = ksr_pkg::ValW'(fval_w[DEPTH-1]);
          if (req_q.command == ksr_pkg::CMD_REMOVE) begin
            cnt_d = cnt_q - CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
    rsp_d.entry_count = ksr_pkg::CountW'(cnt_d);
    rsp_d.is_empty    = (cnt_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      pend_q <= start & ~pend_q;
      done_q <= pend_q;
      if (pend_q) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !pend_q) begin
      req_q <= req_i;
    end
    if (pend_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Every accepted request produces its result, registered through pend_q and then done_q.
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("request did not complete two cycles after acceptance");

  // Results never come back to back, since each request needs an execute cycle.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // The empty flag agrees with the reported count.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.is_empty == (rsp_o.entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  // The fill count never passes the number of cells.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("fill count exceeds depth");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for the keyed stack with search and removal.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int          RAND_ITEMS  = 800;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 8;

  // Command codes the block treats as no operation.
  localparam logic [ksr_pkg::CmdW-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [ksr_pkg::CmdW-1:0] CMD_UNUSED_HI = 3'd7;

  // Traffic mixes of the random part.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  typedef struct {
    ksr_pkg::req_t req;
    int            reps;
    bit            has_exp;
    ksr_pkg::rsp_t exp;
  } stim_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  ksr_pkg::req_t req_i;
  logic          done_o;
  ksr_pkg::rsp_t rsp_o;

  // Typed-in expectation travelling with the request on the bus.
  logic          row_exp_valid;
  ksr_pkg::rsp_t row_exp;

  // Mirror of the store, updated when a request is accepted.
  logic [ksr_pkg::KeyW-1:0] stk_keys [DEPTH];
  logic [ksr_pkg::ValW-1:0] stk_vals [DEPTH];
  int                       stk_fill;

  ksr_pkg::rsp_t pending_rsp[$];
  stim_row_t     stim_rows[$];
  int            mismatches;
  int            cycles;
  bit            burst_idle;

  keyed_stack_with_removal_top #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("keyed_stack_with_removal_top: mismatch");
      $finish;
    end
  end

  task automatic apply_command(input ksr_pkg::req_t r, output ksr_pkg::rsp_t o);
    int hit;
    hit = -1;
    o = '0;
    o.status = ksr_pkg::ST_OK;
    case (r.command)
      ksr_pkg::CMD_PUSH: begin
        if (stk_fill >= DEPTH) begin
          o.status = ksr_pkg::ST_FULL;
        end else begin
          stk_keys[stk_fill] = r.key;
          stk_vals[stk_fill] = r.value;
          stk_fill++;
        end
      end
      ksr_pkg::CMD_POP, ksr_pkg::CMD_PEEK: begin
        if (stk_fill == 0) begin
          o.status = ksr_pkg::ST_MISS;
        end else begin
          o.out_key   = stk_keys[stk_fill-1];
          o.out_value = stk_vals[stk_fill-1];
          if (r.command == ksr_pkg::CMD_POP) stk_fill--;
        end
      end
      ksr_pkg::CMD_FIND, ksr_pkg::CMD_REMOVE: begin
        // Newest entry wins when keys repeat.
        for (int i = stk_fill - 1; i >= 0; i--) begin
          if (hit < 0 && stk_keys[i] == r.key) hit = i;
        end
        if (hit < 0) begin
          o.status = ksr_pkg::ST_MISS;
        end else begin
          o.out_key   = stk_keys[hit];
          o.out_value = stk_vals[hit];
          if (r.command == ksr_pkg::CMD_REMOVE) begin
            for (int i = hit; i < stk_fill - 1; i++) begin
              stk_keys[i] = stk_keys[i+1];
              stk_vals[i] = stk_vals[i+1];
            end
            stk_fill--;
          end
        end
      end
      default: ;
    endcase
    o.entry_count = stk_fill[ksr_pkg::CountW-1:0];
    o.is_empty    = (stk_fill == 0);
  endtask

  // Results are checked before the request of the same edge is predicted; the block
  // registers every request, so a result never belongs to a request of its own edge.
  always @(posedge clk_i) begin
    ksr_pkg::rsp_t predicted;
    ksr_pkg::rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result at cycle %0d: %p", cycles, rsp_o);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_o.status !== want.status || rsp_o.out_key !== want.out_key ||
              rsp_o.out_value !== want.out_value ||
              rsp_o.entry_count !== want.entry_count ||
              rsp_o.is_empty !== want.is_empty) begin
            mismatches++;
            if (mismatches <= 10)
              $display("cycle %0d: expected st=%0d key=%h val=%h cnt=%0d emp=%0d,",
                       cycles, want.status, want.out_key, want.out_value,
                       want.entry_count, want.is_empty,
                       " got st=%0d key=%h val=%h cnt=%0d emp=%0d",
                       rsp_o.status, rsp_o.out_key, rsp_o.out_value,
                       rsp_o.entry_count, rsp_o.is_empty);
          end
        end
      end
      if (start && !busy) begin
        apply_command(req_i, predicted);
        pending_rsp.push_back(row_exp_valid ? row_exp : predicted);
      end
    end
  end

  task automatic add_row(input logic [ksr_pkg::CmdW-1:0] cmd,
                         input logic [ksr_pkg::KeyW-1:0] key,
                         input logic [ksr_pkg::ValW-1:0] val, input int reps,
                         input bit has_exp, input ksr_pkg::status_e st,
                         input logic [ksr_pkg::KeyW-1:0] okey,
                         input logic [ksr_pkg::ValW-1:0] oval,
                         input logic [ksr_pkg::CountW-1:0] cnt, input logic emp);
    stim_row_t row;
    row.req.command     = cmd;
    row.req.key         = key;
    row.req.value       = val;
    row.reps            = reps;
    row.has_exp         = has_exp;
    row.exp.status      = st;
    row.exp.out_key     = okey;
    row.exp.out_value   = oval;
    row.exp.entry_count = cnt;
    row.exp.is_empty    = emp;
    stim_rows.push_back(row);
  endtask

  function automatic int draw_gap();
    return burst_idle ? $urandom_range(0, 15) : 0;
  endfunction

  // Drives one request and returns once it has been accepted.
  task automatic send_request(input ksr_pkg::req_t r, input bit has_exp,
                              input ksr_pkg::rsp_t e);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    req_i         <= r;
    row_exp_valid <= has_exp;
    row_exp       <= e;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic logic [ksr_pkg::CmdW-1:0] pick_command(input mix_e mix);
    int roll;
    int push_pct;
    int pop_pct;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin push_pct = 55; pop_pct = 10; end
      MIX_DRAIN: begin push_pct = 15; pop_pct = 40; end
      default:   begin push_pct = 30; pop_pct = 20; end
    endcase
    if (roll < push_pct) return ksr_pkg::CMD_PUSH;
    roll -= push_pct;
    if (roll < pop_pct) return ksr_pkg::CMD_POP;
    roll -= pop_pct;
    if (roll < 10) return ksr_pkg::CMD_PEEK;
    if (roll < 30) return ksr_pkg::CMD_FIND;
    if (roll < 47) return ksr_pkg::CMD_REMOVE;
    return logic'($urandom_range(0, 1)) ? CMD_UNUSED_LO : 3'($urandom_range(5, 7));
  endfunction

  function automatic logic [ksr_pkg::KeyW-1:0] pick_key(
      input logic [ksr_pkg::CmdW-1:0] cmd);
    int roll;
    roll = $urandom_range(0, 99);
    // Searches mostly aim at keys that are stored, so hits and removals are common.
    if ((cmd == ksr_pkg::CMD_FIND || cmd == ksr_pkg::CMD_REMOVE) && stk_fill > 0 &&
        roll < 60)
      return stk_keys[$urandom_range(0, stk_fill - 1)];
    if (roll < 70) return ksr_pkg::KeyW'($urandom_range(0, 7));
    if (roll < 80) return logic'($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
    return ksr_pkg::KeyW'($urandom);
  endfunction

  function automatic logic [ksr_pkg::ValW-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  initial begin
    stim_row_t     row;
    ksr_pkg::req_t r;
    ksr_pkg::rsp_t none;
    mix_e          mix;
    int            burst_left;
    none          = '0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    row_exp_valid = 1'b0;
    row_exp       = '0;
    stk_fill      = 0;
    mismatches    = 0;
    cycles        = 0;
    burst_idle    = 1'b1;
    foreach (stk_keys[i]) begin
      stk_keys[i] = '0;
      stk_vals[i] = '0;
    end

    // Empty store, unused codes, duplicates, removal of the oldest entry, then a full store.
    add_row(ksr_pkg::CMD_POP,    16'h0000, 32'h0000_0000, 1, 1,
            ksr_pkg::ST_MISS, 16'h0, 32'h0, 0, 1);
    add_row(ksr_pkg::CMD_PEEK,   16'h0000, 32'h0000_0000, 1, 1,
            ksr_pkg::ST_MISS, 16'h0, 32'h0, 0, 1);
    add_row(ksr_pkg::CMD_FIND,   16'h0000, 32'h0000_0000, 1, 1,
            ksr_pkg::ST_MISS, 16'h0, 32'h0, 0, 1);
    add_row(ksr_pkg::CMD_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1, 1,
            ksr_pkg::ST_MISS, 16'h0, 32'h0, 0, 1);
    add_row(CMD_UNUSED_LO,       16'hFFFF, 32'hFFFF_FFFF, 1, 1,
            ksr_pkg::ST_OK, 16'h0, 32'h0, 0, 1);
    add_row(CMD_UNUSED_HI,       16'hFFFF, 32'hFFFF_FFFF, 1, 1,
            ksr_pkg::ST_OK, 16'h0, 32'h0, 0, 1);
    add_row(ksr_pkg::CMD_PUSH,   16'h0000, 32'h0000_0000, 1, 1,
            ksr_pkg::ST_OK, 16'h0, 32'h0, 1, 0);
    add_row(ksr_pkg::CMD_PUSH,   16'hFFFF, 32'hFFFF_FFFF, 1, 1,
            ksr_pkg::ST_OK, 16'h0, 32'h0, 2, 0);
    add_row(ksr_pkg::CMD_PUSH,   16'hFFFF, 32'h0000_0001, 1, 1,
            ksr_pkg::ST_OK, 16'h0, 32'h0, 3, 0);
    add_row(ksr_pkg::CMD_FIND,   16'hFFFF, 32'h0000_0000, 1, 1,
            ksr_pkg::ST_OK, 16'hFFFF, 32'h1, 3, 0);
    add_row(ksr_pkg::CMD_REMOVE, 16'hFFFF, 32'h0000_0000, 1, 1,
            ksr_pkg::ST_OK, 16'hFFFF, 32'h1, 2, 0);
    add_row(ksr_pkg::CMD_FIND,   16'hFFFF, 32'h0000_0000, 1, 1,
            ksr_pkg::ST_OK, 16'hFFFF, 32'hFFFF_FFFF, 2, 0);
    add_row(ksr_pkg::CMD_REMOVE, 16'h0000, 32'h0000_0000, 1, 1,
            ksr_pkg::ST_OK, 16'h0, 32'h0, 1, 0);
    add_row(ksr_pkg::CMD_FIND,   16'h0000, 32'h0000_0000, 1, 1,
            ksr_pkg::ST_MISS, 16'h0, 32'h0, 1, 0);
    add_row(ksr_pkg::CMD_PEEK,   16'h0000, 32'h0000_0000, 1, 1,
            ksr_pkg::ST_OK, 16'hFFFF, 32'hFFFF_FFFF, 1, 0);
    add_row(ksr_pkg::CMD_PUSH,   16'h0100, 32'h5A5A_0000, 15, 0,
            ksr_pkg::ST_OK, 16'h0, 32'h0, 0, 0);
    add_row(ksr_pkg::CMD_PUSH,   16'h0BAD, 32'hDEAD_BEEF, 1, 1,
            ksr_pkg::ST_FULL, 16'h0, 32'h0, 16, 0);
    add_row(ksr_pkg::CMD_FIND,   16'h0100, 32'h0000_0000, 1, 0,
            ksr_pkg::ST_OK, 16'h0, 32'h0, 0, 0);
    add_row(ksr_pkg::CMD_REMOVE, 16'h0107, 32'h0000_0000, 1, 0,
            ksr_pkg::ST_OK, 16'h0, 32'h0, 0, 0);
    add_row(ksr_pkg::CMD_PEEK,   16'h0000, 32'h0000_0000, 1, 0,
            ksr_pkg::ST_OK, 16'h0, 32'h0, 0, 0);
    add_row(ksr_pkg::CMD_POP,    16'h0000, 32'h0000_0000, 16, 0,
            ksr_pkg::ST_OK, 16'h0, 32'h0, 0, 0);
    add_row(ksr_pkg::CMD_POP,    16'h0000, 32'h0000_0000, 1, 1,
            ksr_pkg::ST_MISS, 16'h0, 32'h0, 0, 1);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[n]) begin
      row = stim_rows[n];
      burst_idle = (n % 4) != 3;
      for (int k = 0; k < row.reps; k++) begin
        r = row.req;
        r.key   = row.req.key + ksr_pkg::KeyW'(k);
        r.value = row.req.value ^ ksr_pkg::ValW'(k);
        send_request(r, row.has_exp, row.exp);
      end
    end

    // Random part in bursts; each burst has its own mix and either idles or streams.
    burst_left = 0;
    mix = MIX_EVEN;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 60);
        mix        = mix_e'($urandom_range(0, 2));
        burst_idle = $urandom_range(0, 2) != 0;
      end
      burst_left--;
      r.command = pick_command(mix);
      r.key     = pick_key(r.command);
      r.value   = pick_value();
      send_request(r, 1'b0, none);
    end
    start         <= 1'b0;
    row_exp_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("keyed_stack_with_removal_top: match");
    end else begin
      $display("keyed_stack_with_removal_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ksr_pkg.sv
sv/ksr_cell.sv
sv/keyed_stack_with_removal_top.sv
bench/testbench.sv
